>>> hdl/mrdr_pkg.sv
package mrdr_pkg;

  localparam int SIZE_BITS  = 17;
  localparam int PROD_BITS  = 18;
  localparam int RADIX_BITS = 4;
  localparam int CNT_BITS   = 5;
  localparam int CFG_BITS   = 2;
  localparam int COUNT_BITS = 4;
  localparam int LIST_BITS  = 64;

  // running products saturate here; any real size is below it
  localparam logic [PROD_BITS-1:0] PROD_SAT = {PROD_BITS{1'b1}};

  localparam logic [CFG_BITS-1:0] CFG_SIZE  = 2'd0;
  localparam logic [CFG_BITS-1:0] CFG_COUNT = 2'd1;
  localparam logic [CFG_BITS-1:0] CFG_RADIX = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic [SIZE_BITS-1:0] rem;
    logic [SIZE_BITS-1:0] acc;
    logic [1:0]           status;
  } mrdr_item_t;

  typedef struct packed {
    logic busy;
    logic mismatch;
  } mrdr_cfg_stat_t;

  function automatic logic [PROD_BITS-1:0] sat_mul(input logic [PROD_BITS-1:0] a,
                                                   input logic [RADIX_BITS-1:0] r);
    logic [PROD_BITS+RADIX_BITS-1:0] p;
    p = (PROD_BITS+RADIX_BITS)'(a) * (PROD_BITS+RADIX_BITS)'(r);
    if (p > (PROD_BITS+RADIX_BITS)'(PROD_SAT)) begin
      return PROD_SAT;
    end
    return p[PROD_BITS-1:0];
  endfunction

endpackage

>>> hdl/mixed_radix_digit_reverse_index.sv
// Mixed-radix digit-reversal index generator.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets the
// transform size, 1 the stage count, 2 the packed 4-bit radices; other indexes
// are dropped. cfg_ready is always high. Each write, and reset, starts a weight
// sweep over the radix list (one stage per cycle through a saturating
// multiplier); sample_ready stays low until it ends.
// Sample channel (sample_valid/sample_ready, sample_index) takes one request per
// cycle while sample_ready is high. Each request walks a pipeline of MAX_STAGES+1
// registers: an entry stage that checks the radix product and the index range,
// then one stage per radix that pulls out one digit by a 4-step restoring divide
// and adds its reversed weight. The last stage drives result_valid/reversed_index/
// status; throughput is one per cycle unless result_ready or a sweep holds it.
// status is 0 ok, 1 radix product differs from the size, 2 index out of range;
// reversed_index is 0 on either error.
// When result_ready is low the last stage holds; earlier stages keep filling
// empty slots; outside a sweep, sample_ready drops only once the pipeline is full.
// Reset clears all valid bits and restores size 1, one stage, radix 1.
module mixed_radix_digit_reverse_index import mrdr_pkg::*; #(
  parameter int MAX_STAGES = 15,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_BITS-1:0]   cfg_index,
  input  logic [LIST_BITS-1:0]  cfg_data,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  logic [INDEX_BITS-1:0] sample_index,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [INDEX_BITS-1:0] reversed_index,
  output logic [1:0]            status
);

  localparam int WW = (INDEX_BITS > SIZE_BITS) ? INDEX_BITS : SIZE_BITS;

  logic [SIZE_BITS-1:0]  size;
  mrdr_cfg_stat_t        cfg_stat;
  logic [PROD_BITS-1:0]  w_tab [0:MAX_STAGES-1];
  logic [PROD_BITS-1:0]  v_tab [0:MAX_STAGES-1];
  logic [MAX_STAGES-1:0] stage_on;

  logic                  vld  [0:MAX_STAGES];
  mrdr_item_t            item [0:MAX_STAGES];
  logic                  en   [0:MAX_STAGES];
  logic [WW-1:0]         n_wide;
  logic                  accept;
  mrdr_item_t            entry_next;

  assign cfg_ready = 1'b1;

  mrdr_cfg #(.MAX_STAGES(MAX_STAGES)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr       (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .size     (size),
    .stat     (cfg_stat),
    .w_tab    (w_tab),
    .v_tab    (v_tab),
    .stage_on (stage_on)
  );

  // a stage may load when it is empty or its successor loads
  assign en[MAX_STAGES] = !vld[MAX_STAGES] || result_ready;
  for (genvar i = 0; i < MAX_STAGES; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end

  assign sample_ready = en[0] && !cfg_stat.busy;
  assign accept       = sample_valid && sample_ready;
  assign n_wide       = WW'(sample_index);

  always_comb begin
    entry_next.rem = SIZE_BITS'(n_wide);
    entry_next.acc = '0;
    if (cfg_stat.mismatch) begin
      entry_next.status = ST_MISMATCH;
    end else if (n_wide >= WW'(size)) begin
      entry_next.status = ST_RANGE;
    end else begin
      entry_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      item[0] <= entry_next;
    end
  end

  // pipeline stage j handles radix stage MAX_STAGES-1-j, top digit first
  for (genvar j = 0; j < MAX_STAGES; j++) begin : g_stage
    mrdr_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .load      (en[j+1]),
      .in_valid  (vld[j]),
      .in_item   (item[j]),
      .weight    (w_tab[MAX_STAGES-1-j]),
      .scale     (v_tab[MAX_STAGES-1-j]),
      .active    (stage_on[MAX_STAGES-1-j]),
      .out_valid (vld[j+1]),
      .out_item  (item[j+1])
    );
  end

  assign result_valid   = vld[MAX_STAGES];
  assign status         = item[MAX_STAGES].status;
  assign reversed_index = (item[MAX_STAGES].status == ST_OK)
                          ? INDEX_BITS'(WW'(item[MAX_STAGES].acc)) : '0;

  a_ready_not_busy: assert property (@(posedge clk) disable iff (rst)
    sample_ready |-> !cfg_stat.busy)
    else $error("request taken during weight sweep");

  a_mismatch_tagged: assert property (@(posedge clk) disable iff (rst)
    accept && cfg_stat.mismatch |=> vld[0] && item[0].status == ST_MISMATCH)
    else $error("product mismatch not tagged at entry");

  a_entry_holds: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !en[0] |=> vld[0] && $stable(item[0]))
    else $error("entry stage lost a stalled request");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status == ST_OK || status == ST_MISMATCH || status == ST_RANGE)
    else $error("bad status code");

endmodule

>>> hdl/mrdr_stage.sv
module mrdr_stage import mrdr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 in_valid,
  input  mrdr_item_t           in_item,
  input  logic [PROD_BITS-1:0] weight,
  input  logic [PROD_BITS-1:0] scale,
  input  logic                 active,
  output logic                 out_valid,
  output mrdr_item_t           out_item
);

  localparam int CW = PROD_BITS + 3;

  logic [SIZE_BITS-1:0]  rem;
  logic [RADIX_BITS-1:0] digit;
  logic [CW-1:0]         shifted;
  logic [PROD_BITS+RADIX_BITS-1:0] term;
  mrdr_item_t            item_next;

  // restoring division of the remainder by the stage weight, one digit bit per step
  always_comb begin
    rem   = in_item.rem;
    digit = '0;
    for (int b = RADIX_BITS - 1; b >= 0; b--) begin
      shifted = CW'(weight) << b;
      if (CW'(rem) >= shifted) begin
        rem      = rem - shifted[SIZE_BITS-1:0];
        digit[b] = 1'b1;
      end
    end
    term = (PROD_BITS+RADIX_BITS)'(digit) * (PROD_BITS+RADIX_BITS)'(scale);
    item_next = in_item;
    if (active) begin
      item_next.rem = rem;
      item_next.acc = in_item.acc + term[SIZE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
    end
  end

endmodule

>>> hdl/mrdr_cfg.sv
module mrdr_cfg import mrdr_pkg::*; #(
  parameter int MAX_STAGES = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  logic [CFG_BITS-1:0]   wr_index,
  input  logic [LIST_BITS-1:0]  wr_data,
  output logic [SIZE_BITS-1:0]  size,
  output mrdr_cfg_stat_t        stat,
  output logic [PROD_BITS-1:0]  w_tab [0:MAX_STAGES-1],
  output logic [PROD_BITS-1:0]  v_tab [0:MAX_STAGES-1],
  output logic [MAX_STAGES-1:0] stage_on
);

  localparam int TW = $clog2(MAX_STAGES + 1);
  localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  typedef enum logic [1:0] {SEQ_FWD, SEQ_BWD, SEQ_DONE} seq_state_t;

  seq_state_t             state;
  logic [TW-1:0]          step;
  logic [PROD_BITS-1:0]   run;
  logic [PROD_BITS-1:0]   prod_next;
  logic [COUNT_BITS-1:0]  count_q;
  logic [LIST_BITS-1:0]   radix_q;
  logic [LIST_BITS-1:0]   radix_shift;
  logic [CNT_BITS-1:0]    cnt_eff;
  logic                   in_use;
  logic [PROD_BITS-1:0]   w_q [1:MAX_STAGES];
  logic [PROD_BITS-1:0]   v_q [0:MAX_STAGES-1];

  assign cnt_eff = (CNT_BITS'(count_q) > CNT_BITS'(MAX_STAGES)) ? CNT_BITS'(MAX_STAGES)
                                                               : CNT_BITS'(count_q);
  assign radix_shift = radix_q >> {step, 2'b00};
  assign in_use      = CNT_BITS'(step) < cnt_eff;
  assign prod_next   = in_use ? sat_mul(run, radix_shift[RADIX_BITS-1:0]) : run;

  // forward sweep builds the digit weights, backward sweep the reversed weights
  always_ff @(posedge clk) begin
    if (rst) begin
      size    <= SIZE_BITS'(1);
      count_q <= COUNT_BITS'(1);
      radix_q <= LIST_BITS'(1);
      state   <= SEQ_FWD;
      step    <= '0;
      run     <= PROD_BITS'(1);
    end else if (wr) begin
      case (wr_index)
        CFG_SIZE:  size    <= wr_data[SIZE_BITS-1:0];
        CFG_COUNT: count_q <= wr_data[COUNT_BITS-1:0];
        CFG_RADIX: radix_q <= wr_data;
        default: ;
      endcase
      state <= SEQ_FWD;
      step  <= '0;
      run   <= PROD_BITS'(1);
    end else begin
      case (state)
        SEQ_FWD: begin
          w_q[TW'(step + TW'(1))] <= prod_next;
          if (step == TW'(MAX_STAGES - 1)) begin
            state <= SEQ_BWD;
            run   <= PROD_BITS'(1);
          end else begin
            step <= step + TW'(1);
            run  <= prod_next;
          end
        end
        SEQ_BWD: begin
          v_q[SW'(step)] <= run;
          run            <= prod_next;
          if (step == '0) begin
            state <= SEQ_DONE;
          end else begin
            step <= step - TW'(1);
          end
        end
        SEQ_DONE: ;
        default: state <= SEQ_DONE;
      endcase
    end
  end

  always_comb begin
    w_tab[0] = PROD_BITS'(1);
    for (int i = 1; i < MAX_STAGES; i++) begin
      w_tab[i] = w_q[i];
    end
    for (int i = 0; i < MAX_STAGES; i++) begin
      v_tab[i]    = v_q[i];
      stage_on[i] = CNT_BITS'(i) < cnt_eff;
    end
  end

  assign stat.busy     = state != SEQ_DONE;
  assign stat.mismatch = w_q[MAX_STAGES] != {1'b0, size};

  a_wr_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    wr |=> stat.busy)
    else $error("config write did not restart the weight sweep");

  a_sweep_ends_at_zero: assert property (@(posedge clk) disable iff (rst)
    $fell(stat.busy) |-> $past(state) == SEQ_BWD && $past(step) == '0)
    else $error("weight sweep ended early");

endmodule

>>> tb/tb_mixed_radix_digit_reverse_index.sv
module tb_mixed_radix_digit_reverse_index import mrdr_pkg::*; ();

  localparam logic [CFG_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [15:0] idx;
    logic [1:0]  status;
  } reversal_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_BITS-1:0]   cfg_index = '0;
  logic [LIST_BITS-1:0]  cfg_data = '0;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  logic [15:0]           sample_index = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic [15:0]           reversed_index;
  logic [1:0]            status;

  // shadow copy of the config registers
  logic [SIZE_BITS-1:0]  cfg_size = 17'd1;
  logic [COUNT_BITS-1:0] cfg_count = 4'd1;
  logic [LIST_BITS-1:0]  cfg_radix = 64'd1;

  logic [15:0] index_feed[$];
  reversal_t   reversal_q[$];
  int          errors = 0;

  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_mode = 0;
  int          stall_left = 0;
  logic [31:0] cyc = '0;
  reversal_t   want;

  mixed_radix_digit_reverse_index dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .sample_index   (sample_index),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .reversed_index (reversed_index),
    .status         (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void enqueue_index(input logic [15:0] v);
    index_feed = {index_feed, v};
  endfunction

  function automatic reversal_t digit_reverse(input logic [15:0] n);
    longint unsigned prod;
    longint unsigned k;
    longint unsigned nx;
    longint unsigned ny;
    longint unsigned ni;
    int              cnt;
    reversal_t       r;
    cnt  = int'(cfg_count);
    prod = 1;
    for (int s = 0; s < cnt; s++) prod = prod * cfg_radix[4*s +: 4];
    r = '0;
    if (prod != longint'(cfg_size)) begin
      r.status = ST_MISMATCH;
    end else if (n >= cfg_size) begin
      r.status = ST_RANGE;
    end else begin
      k  = 64'(n);
      nx = (cnt > 0) ? 64'(cfg_radix[3:0]) : 64'd1;
      for (int s = 1; s < cnt; s++) begin
        ny = 64'(cfg_radix[4*s +: 4]);
        ni = nx * ny;
        k  = (k * ny) % ni + (k / nx) % ny + ni * (k / ni);
        nx = ni;
      end
      r.idx    = k[15:0];
      r.status = ST_OK;
    end
    return r;
  endfunction

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else begin
      if (sample_valid && sample_ready) reversal_q = {reversal_q, digit_reverse(sample_index)};
      if (!sample_valid || sample_ready) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          sample_valid <= 1'b0;
        end else if (index_feed.size() > 0) begin
          sample_valid <= 1'b1;
          sample_index <= index_feed.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results and stalls on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_mode   <= 0;
      stall_left   <= 0;
      cyc          <= '0;
    end else begin
      cyc <= cyc + 1;
      if (result_valid && result_ready) begin
        if (reversal_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: reversed_index=%0d status=%0d", reversed_index,
                     status);
          errors++;
        end else begin
          want = reversal_q.pop_front();
          if (reversed_index !== want.idx || status !== want.status) begin
            if (errors < 10)
              $display("mismatch: expected index=%0d status=%0d, got index=%0d status=%0d",
                       want.idx, want.status, reversed_index, status);
            errors++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 80);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: begin
          result_ready <= 1'b1;
        end
        1: begin
          result_ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          result_ready <= ($urandom_range(0, 7) == 0);
        end
        default: begin
          result_ready <= cyc[2];
        end
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_BITS-1:0] idx, input logic [LIST_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SIZE: begin
        cfg_size = data[SIZE_BITS-1:0];
      end
      CFG_COUNT: begin
        cfg_count = data[COUNT_BITS-1:0];
      end
      CFG_RADIX: begin
        cfg_radix = data;
      end
      default: begin
      end
    endcase
  endtask

  // upper bits of size and count data carry junk that the block must drop
  task automatic setup(input logic [SIZE_BITS-1:0] size, input logic [3:0] cnt,
                       input logic [LIST_BITS-1:0] list);
    logic [LIST_BITS-1:0] d;
    d = {$urandom(), $urandom()};
    d[SIZE_BITS-1:0] = size;
    write_reg(CFG_SIZE, d);
    d = {$urandom(), $urandom()};
    d[3:0] = cnt;
    write_reg(CFG_COUNT, d);
    write_reg(CFG_RADIX, list);
  endtask

  task automatic random_setup();
    logic [LIST_BITS-1:0] list;
    longint unsigned      prod;
    logic [SIZE_BITS-1:0] size;
    int                   cnt;
    int                   r;
    cnt  = $urandom_range(0, 15);
    list = {$urandom(), $urandom()};
    prod = 1;
    for (int s = 0; s < cnt; s++) begin
      r = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 5);
      if (prod * r > 65536) r = 1;
      if ($urandom_range(0, 40) == 0) r = 0;
      list[4*s +: 4] = RADIX_BITS'(r);
      prod = prod * r;
    end
    case ($urandom_range(0, 9))
      0: begin
        size = SIZE_BITS'($urandom_range(0, 65536));
      end
      1: begin
        size = SIZE_BITS'(prod + 1);
      end
      default: begin
        size = SIZE_BITS'(prod);
      end
    endcase
    setup(size, 4'(cnt), list);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, {$urandom(), $urandom()});
  endtask

  task automatic queue_random(input int count);
    logic [15:0] v;
    int          r;
    @(negedge clk);
    repeat (count) begin
      r = $urandom_range(0, 9);
      if (cfg_size == 0 || r == 0) v = 16'($urandom());
      else if (r == 1) v = 16'(cfg_size - 1);
      else if (r == 2) v = 16'(cfg_size);
      else v = 16'($urandom_range(0, cfg_size - 1));
      enqueue_index(v);
    end
  endtask

  // wait until every request has its result, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    while (index_feed.size() != 0 || reversal_q.size() != 0 || sample_valid) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset values: size 1, one stage of radix 1
    @(negedge clk);
    enqueue_index(16'd0);
    enqueue_index(16'd1);
    enqueue_index(16'hFFFF);
    drain();

    // write to an unused register index must change nothing
    write_reg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    @(negedge clk);
    enqueue_index(16'd0);
    enqueue_index(16'd1);
    drain();

    // largest size over all fifteen stages
    setup(17'd65536, 4'd15, 64'hA422_2222_2222_2222);
    @(negedge clk);
    enqueue_index(16'd0);
    enqueue_index(16'd1);
    enqueue_index(16'hFFFF);
    enqueue_index(16'h8000);
    enqueue_index(16'h5555);
    enqueue_index(16'hAAAA);
    drain();

    setup(17'd105, 4'd3, 64'hFFFF_FFFF_FFFF_F753);
    @(negedge clk);
    enqueue_index(16'd0);
    enqueue_index(16'd104);
    enqueue_index(16'd105);
    enqueue_index(16'd52);
    drain();

    // product differs from size
    setup(17'd100, 4'd3, 64'hFFFF_FFFF_FFFF_F753);
    @(negedge clk);
    enqueue_index(16'd0);
    enqueue_index(16'd99);
    drain();

    // zero radix matches only a zero size, which flags every index
    setup(17'd0, 4'd2, 64'h1234_5678_9ABC_DE50);
    @(negedge clk);
    enqueue_index(16'd0);
    enqueue_index(16'd7);
    drain();

    // no stages: product is 1, index passes through
    setup(17'd1, 4'd0, 64'h0F0F_0F0F_0F0F_0F0F);
    @(negedge clk);
    enqueue_index(16'd0);
    enqueue_index(16'd1);
    drain();

    // huge product must not wrap onto the size
    setup(17'd65536, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    @(negedge clk);
    enqueue_index(16'd0);
    drain();

    for (int p = 0; p < 12; p++) begin
      if (p == 0) setup(17'd65536, 4'd15, 64'h5422_2222_2222_2222);
      else if (p == 1) setup(17'd50625, 4'd4, 64'h3C3C_3C3C_3C3C_FFFF);
      else random_setup();
      queue_random(38);
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
hdl/mrdr_pkg.sv
hdl/mrdr_stage.sv
hdl/mrdr_cfg.sv
hdl/mixed_radix_digit_reverse_index.sv
tb/tb_mixed_radix_digit_reverse_index.sv
